// ===== rtl/core/mflm_pkg.sv =====
// ============================================================================
// mflm_pkg: shared types and constants for the frame level meter
// Field widths, register indexes and the structs that pass between the
// lanes, the merge stage and the top level.
// ============================================================================
package mflm_pkg;

    // Field widths
    localparam int SLOT_W     = 32;
    localparam int SAMPLE_W   = 16;
    localparam int SQUARE_W   = 2 * SAMPLE_W;
    localparam int SUM_W      = 50;
    localparam int PEAK_W     = 16;
    localparam int FRAMES_W   = 20;
    localparam int SHIFT_W    = 5;
    localparam int TOP_SHIFT  = 16;

    // Width of the internal saturating frame counter
    localparam int COUNT_BITS = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SHIFT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MIC_SLOT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIC_SHIFT = CFG_IDX_W'(1);

    localparam logic              MIC_SLOT_RESET  = 1'b0;
    localparam logic [SHIFT_W-1:0] MIC_SHIFT_RESET = SHIFT_W'(14);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    // Per-lane control from the top level
    typedef struct packed {
        logic update;   // a frame is transferred this cycle
        logic clear;    // frame ends the period: restart after it
    } lane_ctrl_t;

    // Per-lane totals including the current frame
    typedef struct packed {
        logic [SUM_W-1:0]  square_sum;
        logic [PEAK_W-1:0] peak;
    } lane_level_t;

    // One result item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pcm_sample;
        logic                       report_valid;
        logic [SUM_W-1:0]           left_square_sum;
        logic [SUM_W-1:0]           right_square_sum;
        logic [PEAK_W-1:0]          left_peak;
        logic [PEAK_W-1:0]          right_peak;
        logic [FRAMES_W-1:0]        frames_seen;
    } result_t;

endpackage

// ===== rtl/core/mflm_if.sv =====
// ============================================================================
// mflm_if: valid/ready channels of the frame level meter
// mflm_frame_if carries one stereo frame, mflm_level_if one result item.
// ============================================================================
interface mflm_frame_if;
    import mflm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SLOT_W-1:0] left_slot;
    logic signed [SLOT_W-1:0] right_slot;
    logic                     end_of_period;

    modport source (output valid, output left_slot, output right_slot,
                    output end_of_period, input ready);
    modport sink   (input valid, input left_slot, input right_slot,
                    input end_of_period, output ready);
endinterface

interface mflm_level_if;
    import mflm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pcm_sample;
    logic                       report_valid;
    logic [SUM_W-1:0]           left_square_sum;
    logic [SUM_W-1:0]           right_square_sum;
    logic [PEAK_W-1:0]          left_peak;
    logic [PEAK_W-1:0]          right_peak;
    logic [FRAMES_W-1:0]        frames_seen;

    modport source (output valid, output pcm_sample, output report_valid,
                    output left_square_sum, output right_square_sum,
                    output left_peak, output right_peak, output frames_seen,
                    input ready);
    modport sink   (input valid, input pcm_sample, input report_valid,
                    input left_square_sum, input right_square_sum,
                    input left_peak, input right_peak, input frames_seen,
                    output ready);
endinterface

// ===== rtl/core/mflm_lane.sv =====
// ============================================================================
// mflm_lane: one channel of the level meter
// Takes the top 16 bits of a slot, squares the magnitude into a saturating
// sum and tracks the peak magnitude over the period.
// ============================================================================
module mflm_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [mflm_pkg::SLOT_W-1:0]    slot,
    input  mflm_pkg::lane_ctrl_t                  ctrl,
    output mflm_pkg::lane_level_t                 level
);
    import mflm_pkg::*;

    logic [SUM_W-1:0]           acc_reg;
    logic [SUM_W-1:0]           acc_next;
    logic [PEAK_W-1:0]          peak_reg;
    logic [PEAK_W-1:0]          peak_next;
    logic signed [SAMPLE_W-1:0] top;
    logic [SAMPLE_W-1:0]        mag;
    logic [SQUARE_W-1:0]        square;
    logic [SUM_W:0]             sum_wide;

    // Top half of the slot and its magnitude (-32768 maps to 0x8000)
    assign top    = slot[SLOT_W-1:TOP_SHIFT];
    assign mag    = top[SAMPLE_W-1] ? (~top + SAMPLE_W'(1)) : top;
    assign square = mag * mag;

    // Accumulate with saturation at the all-ones value
    assign sum_wide = {1'b0, acc_reg} + (SUM_W + 1)'(square);
    assign acc_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // Track the peak
    assign peak_next = (mag > peak_reg) ? mag : peak_reg;

    assign level.square_sum = acc_next;
    assign level.peak       = peak_next;

    // Advance on each transfer, restart after the end of a period
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            peak_reg <= '0;
        end
        else if (ctrl.update)
        begin
            if (ctrl.clear)
            begin
                acc_reg  <= '0;
                peak_reg <= '0;
            end
            else
            begin
                acc_reg  <= acc_next;
                peak_reg <= peak_next;
            end
        end
    end

endmodule

// ===== rtl/core/mflm_merge.sv =====
// ============================================================================
// mflm_merge: merge stage of the level meter
// Counts frames, forms the PCM sample, combines both lanes into one result
// and holds it in an output register backed by a skid register.
// ============================================================================
module mflm_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic                                  eop,
    input  logic signed [mflm_pkg::SLOT_W-1:0]    pcm_src,
    input  logic [mflm_pkg::SHIFT_W-1:0]          shift,
    input  mflm_pkg::lane_level_t                 left_lvl,
    input  mflm_pkg::lane_level_t                 right_lvl,
    output logic                                  in_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output mflm_pkg::result_t                     out_data
);
    import mflm_pkg::*;

    logic [COUNT_BITS-1:0]            tally_reg;
    logic [COUNT_BITS-1:0]            tally_next;
    logic [COUNT_BITS+FRAMES_W-1:0]   tally_ext;
    logic signed [SLOT_W-1:0]         shifted;
    logic signed [SAMPLE_W-1:0]       pcm;
    result_t                          fresh;
    result_t                          out_reg;
    result_t                          skid_reg;
    logic                             out_valid_reg;
    logic                             skid_valid_reg;
    logic                             pop;

    // Saturating frame count including this frame
    assign tally_next = (&tally_reg) ? tally_reg : tally_reg + COUNT_BITS'(1);
    assign tally_ext  = {{FRAMES_W{1'b0}}, tally_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else if (take)
        begin
            tally_reg <= eop ? '0 : tally_next;
        end
    end

    // Shift the selected slot and clamp to 16 bits
    assign shifted = pcm_src >>> shift;

    always_comb
    begin
        priority if (!shifted[SLOT_W-1] && (|shifted[SLOT_W-2:SAMPLE_W-1]))
        begin
            pcm = SAMPLE_MAX;
        end
        else if (shifted[SLOT_W-1] && !(&shifted[SLOT_W-2:SAMPLE_W-1]))
        begin
            pcm = SAMPLE_MIN;
        end
        else
        begin
            pcm = shifted[SAMPLE_W-1:0];
        end
    end

    // Combine lanes; level fields are zero outside a report
    always_comb
    begin
        fresh.pcm_sample   = pcm;
        fresh.report_valid = eop;
        if (eop)
        begin
            fresh.left_square_sum  = left_lvl.square_sum;
            fresh.right_square_sum = right_lvl.square_sum;
            fresh.left_peak        = left_lvl.peak;
            fresh.right_peak       = right_lvl.peak;
            fresh.frames_seen      = tally_ext[FRAMES_W-1:0];
        end
        else
        begin
            fresh.left_square_sum  = '0;
            fresh.right_square_sum = '0;
            fresh.left_peak        = '0;
            fresh.right_peak       = '0;
            fresh.frames_seen      = '0;
        end
    end

    // Output register with skid: accept while the skid slot is free
    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (take)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= fresh;
            end
            else
            begin
                out_reg <= fresh;
            end
        end
    end

endmodule

// ===== rtl/core/mic_frame_level_meter_top.sv =====
// ============================================================================
// mic_frame_level_meter_top: stereo microphone frame level meter
// Two metering lanes (left, right) run side by side on each frame; a merge
// stage counts frames, forms the PCM sample and reports period totals.
// ============================================================================
//
//   channel   direction  handshake       payload
//   frame     in         valid/ready     left_slot, right_slot, end_of_period
//   level     out        valid/ready     pcm_sample, report_valid, sums,
//                                        peaks, frames_seen
//   cfg_*     in         write enable    cfg_index, cfg_data
//
// One frame per clock while frame.ready is high; each result is registered in the
// output register, or in the skid register while the sink stalls. Each lane forms
// one 16x16 square and a 50-bit add. A two-deep output (register plus skid) takes
// one more frame while the sink stalls; frame.ready drops only when both entries are full.
// Reset clears the sums, peaks, frame count and output valids, and loads
// mic_slot = 0 and mic_shift = 14.
// ============================================================================
module mic_frame_level_meter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    mflm_frame_if.sink                        frame,
    mflm_level_if.source                      level,
    input  logic                              cfg_we,
    input  logic [mflm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mflm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mflm_pkg::*;

    logic                     mic_slot_reg;
    logic [SHIFT_W-1:0]       mic_shift_reg;
    logic                     take;
    lane_ctrl_t               ctrl;
    lane_level_t              left_lvl;
    lane_level_t              right_lvl;
    logic signed [SLOT_W-1:0] pcm_src;
    result_t                  res;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mic_slot_reg  <= MIC_SLOT_RESET;
            mic_shift_reg <= MIC_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIC_SLOT:  mic_slot_reg  <= cfg_data[0];
                CFG_MIC_SHIFT: mic_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Frame transfer and lane control
    assign take        = frame.valid && frame.ready;
    assign ctrl.update = take;
    assign ctrl.clear  = frame.end_of_period;
    assign pcm_src     = mic_slot_reg ? frame.right_slot : frame.left_slot;

    mflm_lane u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (frame.left_slot),
        .ctrl  (ctrl),
        .level (left_lvl)
    );

    mflm_lane u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (frame.right_slot),
        .ctrl  (ctrl),
        .level (right_lvl)
    );

    mflm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .eop       (frame.end_of_period),
        .pcm_src   (pcm_src),
        .shift     (mic_shift_reg),
        .left_lvl  (left_lvl),
        .right_lvl (right_lvl),
        .in_ready  (frame.ready),
        .out_valid (level.valid),
        .out_ready (level.ready),
        .out_data  (res)
    );

    // Drive the result channel
    assign level.pcm_sample       = res.pcm_sample;
    assign level.report_valid     = res.report_valid;
    assign level.left_square_sum  = res.left_square_sum;
    assign level.right_square_sum = res.right_square_sum;
    assign level.left_peak        = res.left_peak;
    assign level.right_peak       = res.right_peak;
    assign level.frames_seen      = res.frames_seen;

endmodule

// ===== rtl/core/mflm_checker.sv =====
// ============================================================================
// mflm_checker: port-level checks for the frame level meter
// Watches the channels of the top level and is bound to it below.
// ============================================================================
module mflm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input mflm_pkg::result_t                out_data
);
    import mflm_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

    // After a frame transfer the output is always valid in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
    else $error("frame transfer produced no result");

    // Level fields stay zero without a report
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.report_valid |->
            out_data.left_square_sum == '0 && out_data.right_square_sum == '0 &&
            out_data.left_peak == '0 && out_data.right_peak == '0 &&
            out_data.frames_seen == '0)
    else $error("level fields set outside a report");

    // A report covers at least one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.report_valid |-> out_data.frames_seen != '0)
    else $error("report with zero frames");

    // Peaks never exceed the 16-bit magnitude range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.left_peak <= 16'h8000 &&
                      out_data.right_peak <= 16'h8000)
    else $error("peak out of range");

endmodule

bind mic_frame_level_meter_top mflm_checker u_mflm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (level.valid),
    .out_ready (level.ready),
    .out_data  ({level.pcm_sample, level.report_valid, level.left_square_sum,
                 level.right_square_sum, level.left_peak, level.right_peak,
                 level.frames_seen})
);
